>>> rtl/jfs_pkg.sv
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared types and constants of the jpeg frame size scanner.
// ----------------------------------------------------------------------------
package jfs_pkg;

    // result status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_BAD_DIM   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // dimension limit for a usable size
    localparam logic [15:0] DIM_MAX = 16'h7FFF;

    // widths of the stream payloads
    localparam int IN_TDATA_W  = 8;
    localparam int RES_BITS    = 34;
    localparam int OUT_TDATA_W = 40;

    // one result item
    typedef struct packed {
        logic [15:0] frame_height;
        logic [15:0] frame_width;
        logic [1:0]  scan_status;
    } jfs_result_t;

endpackage

>>> rtl/jfs_scan_core.sv
// ----------------------------------------------------------------------------
// jfs_scan_core
// Marker parser state: one byte per step, gives at most one result per step.
// ----------------------------------------------------------------------------
module jfs_scan_core
    import jfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_valid,
    output jfs_result_t res
);

    // parser phases
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_MARKER = 3'd1;
    localparam logic [2:0] PH_FRAME  = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // marker byte values
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] SOF_FIRST   = 8'hC0;
    localparam logic [7:0] SOF_LAST    = 8'hCF;
    localparam logic [7:0] MARK_DHT    = 8'hC4;
    localparam logic [7:0] MARK_JPG    = 8'hC8;
    localparam logic [7:0] MARK_DAC    = 8'hCC;
    localparam logic [7:0] NOLEN_FIRST = 8'hD0;
    localparam logic [7:0] NOLEN_LAST  = 8'hD9;

    // header byte positions, the 0xFF counting as byte 0
    localparam logic [3:0] POS_FIRST = 4'd2;
    localparam logic [3:0] POS_H_HI  = 4'd5;
    localparam logic [3:0] POS_H_LO  = 4'd6;
    localparam logic [3:0] POS_W_HI  = 4'd7;
    localparam logic [3:0] POS_W_LO  = 4'd8;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  whi_reg, whi_next;
    logic [15:0] skip_reg, skip_next;

    logic        is_sof;
    logic        is_nolen;
    logic        found;
    logic [15:0] seg_len;
    logic [15:0] width_val;

    // marker classes
    always_comb
    begin
        is_sof   = (data_byte inside {[SOF_FIRST:SOF_LAST]}) &&
                   !(data_byte inside {MARK_DHT, MARK_JPG, MARK_DAC});
        is_nolen = data_byte inside {[NOLEN_FIRST:NOLEN_LAST]};
    end

    assign seg_len   = {len_reg[15:8], data_byte};
    assign width_val = {whi_reg, data_byte};

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        whi_next   = whi_reg;
        skip_next  = skip_reg;
        found      = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (data_byte == MARK_PREFIX)
                begin
                    phase_next = PH_MARKER;
                end
            end
            PH_MARKER:
            begin
                if (is_sof)
                begin
                    phase_next = PH_FRAME;
                    pos_next   = POS_FIRST;
                end
                else if (is_nolen)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_FRAME:
            begin
                pos_next = pos_reg + 4'd1;
                case (pos_reg)
                    POS_H_HI: len_next = {data_byte, 8'h00};
                    POS_H_LO: len_next = {len_reg[15:8], data_byte};
                    POS_W_HI: whi_next = data_byte;
                    POS_W_LO:
                    begin
                        found      = 1'b1;
                        phase_next = PH_DONE;
                        pos_next   = pos_reg;
                    end
                    default: ;
                endcase
            end
            PH_LEN_HI:
            begin
                len_next   = {data_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next = seg_len;
                if (seg_len < 16'd3)
                begin
                    skip_next  = 16'd0;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    skip_next  = seg_len - 16'd2;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_reg == 16'd1)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DONE: ;
            default: phase_next = PH_HUNT;
        endcase

        // result on a complete header or at end of stream
        res_valid = found || (last_byte && phase_reg != PH_DONE);
        if (found)
        begin
            res.scan_status  = (width_val != 16'd0 && len_reg != 16'd0 &&
                                width_val <= DIM_MAX && len_reg <= DIM_MAX) ?
                               STATUS_FOUND : STATUS_BAD_DIM;
            res.frame_width  = width_val;
            res.frame_height = len_reg;
        end
        else
        begin
            res.scan_status  = STATUS_NOT_FOUND;
            res.frame_width  = 16'd0;
            res.frame_height = 16'd0;
        end
    end

    // state registers, cleared again after every last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 4'd0;
            len_reg   <= 16'd0;
            whi_reg   <= 8'd0;
            skip_reg  <= 16'd0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg <= PH_HUNT;
                pos_reg   <= 4'd0;
                len_reg   <= 16'd0;
                whi_reg   <= 8'd0;
                skip_reg  <= 16'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                whi_reg   <= whi_next;
                skip_reg  <= skip_next;
            end
        end
    end

endmodule

>>> rtl/jpeg_frame_size_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Scans a jpeg byte stream for a frame header and reports its dimensions.
// ----------------------------------------------------------------------------
// datapath: input register, then the parser step, then the result register to the output
// throughput: one byte per cycle while the output is not stalled, set by the combinational parser step
// between the input register and the output register
// reset: asynchronous, active low; clears the parser and both stage valids
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner
    import jfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] scan_status, [17:2] frame_width,
                                              // [33:18] frame_height, [39:34] zero
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    jfs_result_t out_res_reg;

    logic        out_free;
    logic        step;
    logic        res_valid;
    jfs_result_t res;

    // stage advances whenever the output register can take a result
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jfs_scan_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RES_BITS){1'b0}}, out_res_reg};

endmodule
